FILE: rtl/sha1_pkg.sv
// Shared types and constants for the SHA-1 message hasher.
// Used by sha1_ctrl, sha1_dpath and the sha1_message_hasher top level.
`default_nettype none

package sha1_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned DigWords = 5;
  localparam int unsigned RoundN   = 80;

  localparam logic [WordW-1:0] InitH [DigWords] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  localparam logic [WordW-1:0] K0 = 32'h5a827999;
  localparam logic [WordW-1:0] K1 = 32'h6ed9eba1;
  localparam logic [WordW-1:0] K2 = 32'h8f1bbcdc;
  localparam logic [WordW-1:0] K3 = 32'hca62c1d6;

  localparam logic [WordW-1:0] PadOne   = 32'h80000000;
  localparam logic [6:0]       LastRnd  = 7'd79;
  localparam logic [3:0]       LenHiPos = 4'd14;
  localparam logic [3:0]       LenLoPos = 4'd15;
  localparam logic [2:0]       LastIdx  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_UPDATE,
    ST_PAD,
    ST_OUT
  } sha1_state_t;

  typedef enum logic [2:0] {
    PUSH_IN,
    PUSH_TAIL,
    PUSH_ONE,
    PUSH_ZERO,
    PUSH_LEN_HI,
    PUSH_LEN_LO
  } sha1_push_t;

  typedef struct packed {
    logic       push;
    sha1_push_t push_sel;
    logic       len_add;
    logic       len_tail;
    logic       round_en;
    logic [6:0] round_idx;
    logic       update;
    logic       reload;
    logic [2:0] out_idx;
  } sha1_cmd_t;

  typedef struct packed {
    logic tail_full;
  } sha1_sts_t;

endpackage

`default_nettype wire

FILE: rtl/sha1_message_hasher.sv
// Top level of the SHA-1 message hasher; joins sha1_ctrl and sha1_dpath.
// Depends on sha1_pkg, sha1_ctrl and sha1_dpath.
// A non-final word only fills the block; one that completes a 16-word block starts
// 80 rounds at one round per cycle, followed by one chain update.
// A final word pads to the block end and runs one or two compressions, then
// offers five digest words, one per cycle while out_tready is high.
// Throughput is limited by the single round unit; no word is taken while a block compresses.
// Synchronous active-low reset loads the initial chain and clears length and fill.
`default_nettype none

module sha1_message_hasher
  import sha1_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,  // message_word [31:0], valid_bits [37:32]
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata, // digest_word [31:0], word_index [34:32]
  output logic             out_tlast
);

  sha1_cmd_t   cmd;
  sha1_sts_t   sts;
  logic [31:0] digest_word;

  sha1_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tlast  (out_tlast),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  sha1_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .message_word (in_tdata[31:0]),
    .valid_bits   (in_tdata[37:32]),
    .cmd          (cmd),
    .sts          (sts),
    .digest_word  (digest_word)
  );

  assign out_tdata = {5'd0, cmd.out_idx, digest_word};

endmodule

`default_nettype wire

FILE: rtl/sha1_ctrl.sv
// Controller state machine of the SHA-1 hasher: word fill, rounds, padding, digest output.
// Depends on sha1_pkg; drives sha1_dpath through the command struct.
`default_nettype none

module sha1_ctrl
  import sha1_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  input  wire logic      in_tlast,
  output logic           in_tready,
  output logic           out_tvalid,
  output logic           out_tlast,
  input  wire logic      out_tready,
  input  wire sha1_sts_t sts,
  output sha1_cmd_t      cmd
);

  sha1_state_t state_r, state_nxt;
  logic [3:0]  fill_r, fill_nxt;
  logic [6:0]  round_r, round_nxt;
  logic [2:0]  out_idx_r, out_idx_nxt;
  logic        pad_r, pad_nxt;
  logic        one_pend_r, one_pend_nxt;
  logic        hi_done_r, hi_done_nxt;
  logic        lo_done_r, lo_done_nxt;
  sha1_push_t  pad_sel;
  logic        in_acc, out_acc;

  assign in_acc  = in_tvalid && (state_r == ST_IDLE);
  assign out_acc = out_tready && (state_r == ST_OUT);

  always_comb begin
    if (one_pend_r) begin
      pad_sel = PUSH_ONE;
    end else if ((fill_r == LenHiPos) && !hi_done_r) begin
      pad_sel = PUSH_LEN_HI;
    end else if ((fill_r == LenLoPos) && hi_done_r) begin
      pad_sel = PUSH_LEN_LO;
    end else begin
      pad_sel = PUSH_ZERO;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (fill_r == LenLoPos) begin
            state_nxt = ST_ROUND;
          end else if (in_tlast) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        if (round_r == LastRnd) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (lo_done_r) begin
          state_nxt = ST_OUT;
        end else if (pad_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PAD: begin
        if (fill_r == LenLoPos) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_OUT: begin
        if (out_acc && (out_idx_r == LastIdx)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.push_sel  = PUSH_ZERO;
    cmd.round_idx = round_r;
    cmd.out_idx   = out_idx_r;
    in_tready     = (state_r == ST_IDLE);
    out_tvalid    = (state_r == ST_OUT);
    out_tlast     = (state_r == ST_OUT) && (out_idx_r == LastIdx);
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.push     = 1'b1;
          cmd.len_add  = 1'b1;
          cmd.len_tail = in_tlast;
          if (in_tlast && !sts.tail_full) begin
            cmd.push_sel = PUSH_TAIL;
          end else begin
            cmd.push_sel = PUSH_IN;
          end
        end
      end
      ST_ROUND:  cmd.round_en = 1'b1;
      ST_UPDATE: cmd.update = 1'b1;
      ST_PAD: begin
        cmd.push     = 1'b1;
        cmd.push_sel = pad_sel;
      end
      ST_OUT: begin
        cmd.reload = out_tready && (out_idx_r == LastIdx);
      end
      default: cmd.push = 1'b0;
    endcase
  end

  always_comb begin
    fill_nxt     = fill_r;
    round_nxt    = round_r;
    out_idx_nxt  = out_idx_r;
    pad_nxt      = pad_r;
    one_pend_nxt = one_pend_r;
    hi_done_nxt  = hi_done_r;
    lo_done_nxt  = lo_done_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          fill_nxt = fill_r + 4'd1;
          if (in_tlast) begin
            pad_nxt      = 1'b1;
            one_pend_nxt = sts.tail_full;
          end
        end
      end
      ST_ROUND: begin
        round_nxt = (round_r == LastRnd) ? 7'd0 : round_r + 7'd1;
      end
      ST_PAD: begin
        fill_nxt     = fill_r + 4'd1;
        one_pend_nxt = 1'b0;
        if (pad_sel == PUSH_LEN_HI) begin
          hi_done_nxt = 1'b1;
        end
        if (pad_sel == PUSH_LEN_LO) begin
          lo_done_nxt = 1'b1;
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          if (out_idx_r == LastIdx) begin
            out_idx_nxt = 3'd0;
            pad_nxt     = 1'b0;
            hi_done_nxt = 1'b0;
            lo_done_nxt = 1'b0;
          end else begin
            out_idx_nxt = out_idx_r + 3'd1;
          end
        end
      end
      default: round_nxt = round_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      fill_r     <= '0;
      round_r    <= '0;
      out_idx_r  <= '0;
      pad_r      <= 1'b0;
      one_pend_r <= 1'b0;
      hi_done_r  <= 1'b0;
      lo_done_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      round_r    <= round_nxt;
      out_idx_r  <= out_idx_nxt;
      pad_r      <= pad_nxt;
      one_pend_r <= one_pend_nxt;
      hi_done_r  <= hi_done_nxt;
      lo_done_r  <= lo_done_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sha1_dpath.sv
// Datapath of the SHA-1 hasher: message schedule window, round registers, chain and length.
// Depends on sha1_pkg; controlled by sha1_ctrl through the command struct.
`default_nettype none

module sha1_dpath
  import sha1_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [31:0] message_word,
  input  wire logic [5:0]  valid_bits,
  input  wire sha1_cmd_t   cmd,
  output sha1_sts_t        sts,
  output logic [31:0]      digest_word
);

  logic [31:0] w_r [16];
  logic [31:0] h_r [DigWords];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [63:0] len_r, len_nxt;
  logic [5:0]  vb_sat;
  logic [31:0] push_word, sched_word, w_new;
  logic [31:0] f_val, k_val, t_val;
  logic [31:0] tail_mask;

  assign sts.tail_full = valid_bits[5];
  assign vb_sat        = valid_bits[5] ? 6'd32 : valid_bits;
  assign tail_mask     = ~(32'hffffffff >> vb_sat[4:0]);

  always_comb begin
    case (cmd.push_sel)
      PUSH_IN:     push_word = message_word;
      PUSH_TAIL:   push_word = (message_word & tail_mask) | (PadOne >> vb_sat[4:0]);
      PUSH_ONE:    push_word = PadOne;
      PUSH_LEN_HI: push_word = len_r[63:32];
      PUSH_LEN_LO: push_word = len_r[31:0];
      default:     push_word = '0;
    endcase
  end

  assign sched_word = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
  assign w_new      = cmd.round_en ? {sched_word[30:0], sched_word[31]} : push_word;

  always_comb begin
    case (cmd.round_idx) inside
      [7'd0:7'd19]: begin
        f_val = (b_r & c_r) | (~b_r & d_r);
        k_val = K0;
      end
      [7'd20:7'd39]: begin
        f_val = b_r ^ c_r ^ d_r;
        k_val = K1;
      end
      [7'd40:7'd59]: begin
        f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
        k_val = K2;
      end
      default: begin
        f_val = b_r ^ c_r ^ d_r;
        k_val = K3;
      end
    endcase
  end

  assign t_val = {a_r[26:0], a_r[31:27]} + f_val + e_r + k_val + w_r[0];

  always_comb begin
    len_nxt = len_r;
    if (cmd.reload) begin
      len_nxt = '0;
    end else if (cmd.len_add) begin
      len_nxt = len_r + (cmd.len_tail ? {58'd0, vb_sat} : 64'd32);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push || cmd.round_en) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.reload) begin
      for (int i = 0; i < DigWords; i++) begin
        h_r[i] <= InitH[i];
      end
      a_r <= InitH[0];
      b_r <= InitH[1];
      c_r <= InitH[2];
      d_r <= InitH[3];
      e_r <= InitH[4];
    end else if (cmd.update) begin
      h_r[0] <= h_r[0] + a_r;
      h_r[1] <= h_r[1] + b_r;
      h_r[2] <= h_r[2] + c_r;
      h_r[3] <= h_r[3] + d_r;
      h_r[4] <= h_r[4] + e_r;
      a_r    <= h_r[0] + a_r;
      b_r    <= h_r[1] + b_r;
      c_r    <= h_r[2] + c_r;
      d_r    <= h_r[3] + d_r;
      e_r    <= h_r[4] + e_r;
    end else if (cmd.round_en) begin
      a_r <= t_val;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else begin
      len_r <= len_nxt;
    end
  end

  always_comb begin
    case (cmd.out_idx)
      3'd0:    digest_word = h_r[0];
      3'd1:    digest_word = h_r[1];
      3'd2:    digest_word = h_r[2];
      3'd3:    digest_word = h_r[3];
      default: digest_word = h_r[4];
    endcase
  end

endmodule

`default_nettype wire
